[src/software_timer_slot_table_core_defines.svh]
// Assertion macros for the software timer slot table core.
`ifndef SOFTWARE_TIMER_SLOT_TABLE_CORE_DEFINES_SVH
`define SOFTWARE_TIMER_SLOT_TABLE_CORE_DEFINES_SVH

`ifndef SYNTH
`define STST_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stst assertion failed");
`define STST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stst assertion failed");
`else
`define STST_ASSERT_NOW(label, ante, cons)
`define STST_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[src/stst_pkg.sv]
// Types and constants shared by the software timer slot table core.
package stst_pkg;

	localparam int SLOTS   = 8;
	localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W   = SLOT_W + 1;
	localparam int MAX_OUT = 8;
	localparam int NOUT_W  = 4;
	localparam int RSLOT_W = 3;
	localparam int CMP_W   = 7;

	localparam logic [2:0] ACT_TICK   = 3'd0;
	localparam logic [2:0] ACT_CREATE = 3'd1;
	localparam logic [2:0] ACT_DELETE = 3'd2;
	localparam logic [2:0] ACT_START  = 3'd3;
	localparam logic [2:0] ACT_STOP   = 3'd4;

	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_FULL      = 3'd1;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
	localparam logic [2:0] STAT_EXPIRY    = 3'd3;
	localparam logic [2:0] STAT_IDLE      = 3'd4;

	typedef logic [SLOT_W-1:0] slot_idx_t;

	typedef struct packed {
		logic [2:0] action;
		logic [2:0] slot;
		logic       slot_valid;
		logic [7:0] period;
		logic       has_handler;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [RSLOT_W-1:0] result_slot;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic       handler;
		logic [7:0] period;
		logic [7:0] count;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

[src/stst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module stst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/software_timer_slot_table_core.sv]
// Top level of the software timer slot table core.
//
// Usage: a command item is taken at a rising edge with start high and busy low.
// Results come out on rsp, one per cycle, each marked by a one-cycle strobe;
// the receiver cannot stall, so every result is taken in the cycle it is shown.
// rsp.last marks the final result of a command.
// Delete, start and stop finish in the accept cycle; their single result shows
// in the cycle after, and busy stays low, so these can be issued back to back.
// Actions 5 to 7 give no result.
// Create scans the allocated flags one slot per cycle until a slot is free or
// the last slot is checked; result in the first cycle with busy low again.
// Tick walks the slot RAM one entry per cycle (read, increment, compare, write
// back); expiries stream out in slot order during the walk, and the last result
// shows in the first cycle with busy low again.
// Counters, periods and handler flags sit in one RAM; allocated and running
// flags are flip-flops. During a tick, writes trail reads by one entry, so no
// forwarding is needed.
// Reset clears the flags and the control state; no RAM clearing pass is run.
`include "software_timer_slot_table_core_defines.svh"

module software_timer_slot_table_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  stst_pkg::cmd_t req,
	output logic          strobe,
	output stst_pkg::rsp_t rsp
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_TICK   = 2'd1;
	localparam logic [1:0] S_FIN    = 2'd2;
	localparam logic [1:0] S_CREATE = 2'd3;

	logic [1:0]                   state_q;
	logic [stst_pkg::SLOTS-1:0]   alloc_q;
	logic [stst_pkg::SLOTS-1:0]   run_q;
	logic [stst_pkg::CNT_W-1:0]   scan_q;
	logic                         vld_s1;
	stst_pkg::slot_idx_t          idx_s1;
	logic                         pend_q;
	stst_pkg::slot_idx_t          pend_slot_q;
	logic [stst_pkg::NOUT_W-1:0]  n_q;
	logic [7:0]                   period_q;
	logic                         handler_q;

	logic                         ram_we;
	stst_pkg::slot_idx_t          ram_waddr;
	stst_pkg::entry_t             ram_wdata;
	stst_pkg::slot_idx_t          ram_raddr;
	logic [stst_pkg::ENTRY_W-1:0] ram_rdata;

	stst_pkg::entry_t             rd_ent;
	logic [7:0]                   cnt_inc;
	logic                         fire;
	stst_pkg::slot_idx_t          scan_idx;
	stst_pkg::slot_idx_t          req_idx;
	logic                         req_hit;
	logic                         req_ctl;

	stst_ram #(
		.WIDTH(stst_pkg::ENTRY_W),
		.DEPTH(stst_pkg::SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign busy     = (state_q != S_IDLE);
	assign scan_idx = scan_q[stst_pkg::SLOT_W-1:0];
	assign req_idx  = stst_pkg::SLOT_W'(req.slot);
	assign req_hit  = req.slot_valid &&
		(stst_pkg::CMP_W'(req.slot) < stst_pkg::CMP_W'(stst_pkg::SLOTS));
	assign req_ctl  = req.action inside {stst_pkg::ACT_DELETE, stst_pkg::ACT_START,
		stst_pkg::ACT_STOP};
	assign rd_ent   = stst_pkg::entry_t'(ram_rdata);
	assign cnt_inc  = rd_ent.count + 8'd1;
	assign fire     = alloc_q[idx_s1] && run_q[idx_s1] && (cnt_inc == rd_ent.period);
	assign ram_raddr = scan_idx;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = '{handler: rd_ent.handler, period: rd_ent.period,
			count: (fire && rd_ent.handler) ? 8'd0 : cnt_inc};
		if (state_q == S_TICK && vld_s1) begin
			ram_we = 1'b1;
		end else if (state_q == S_CREATE && !alloc_q[scan_idx]) begin
			ram_we    = 1'b1;
			ram_waddr = scan_idx;
			ram_wdata = '{handler: handler_q, period: period_q, count: 8'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			alloc_q     <= '0;
			run_q       <= '0;
			scan_q      <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			pend_q      <= 1'b0;
			pend_slot_q <= '0;
			n_q         <= '0;
			period_q    <= '0;
			handler_q   <= 1'b0;
			strobe      <= 1'b0;
			rsp         <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					strobe <= start && req_ctl;
					if (start) begin
						case (req.action)
							stst_pkg::ACT_TICK: begin
								state_q <= S_TICK;
								scan_q  <= '0;
								vld_s1  <= 1'b0;
								pend_q  <= 1'b0;
								n_q     <= '0;
							end
							stst_pkg::ACT_CREATE: begin
								state_q   <= S_CREATE;
								scan_q    <= '0;
								period_q  <= req.period;
								handler_q <= req.has_handler;
							end
							stst_pkg::ACT_DELETE, stst_pkg::ACT_START,
							stst_pkg::ACT_STOP: begin
								rsp <= '{status: req_hit ? stst_pkg::STAT_OK
										: stst_pkg::STAT_NOT_FOUND,
									result_slot: '0, last: 1'b1};
								if (req_hit) begin
									run_q[req_idx] <= (req.action == stst_pkg::ACT_START);
									if (req.action == stst_pkg::ACT_DELETE) begin
										alloc_q[req_idx] <= 1'b0;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_TICK: begin
					strobe <= vld_s1 && fire && pend_q &&
						(n_q < stst_pkg::NOUT_W'(stst_pkg::MAX_OUT));
					if (scan_q < stst_pkg::CNT_W'(stst_pkg::SLOTS)) begin
						vld_s1 <= 1'b1;
						idx_s1 <= scan_idx;
						scan_q <= scan_q + 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1) begin
						if (fire && n_q < stst_pkg::NOUT_W'(stst_pkg::MAX_OUT)) begin
							// hold each expiry back until the next one or the end of the walk, so the final one can carry last
							if (pend_q) begin
								rsp <= '{status: stst_pkg::STAT_EXPIRY,
									result_slot: stst_pkg::RSLOT_W'(pend_slot_q), last: 1'b0};
							end
							pend_q      <= 1'b1;
							pend_slot_q <= idx_s1;
							n_q         <= n_q + 1'b1;
						end
						if (idx_s1 == stst_pkg::SLOT_W'(stst_pkg::SLOTS - 1)) begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					strobe  <= 1'b1;
					state_q <= S_IDLE;
					vld_s1  <= 1'b0;
					pend_q  <= 1'b0;
					if (pend_q) begin
						rsp <= '{status: stst_pkg::STAT_EXPIRY,
							result_slot: stst_pkg::RSLOT_W'(pend_slot_q), last: 1'b1};
					end else begin
						rsp <= '{status: stst_pkg::STAT_IDLE, result_slot: '0, last: 1'b1};
					end
				end
				S_CREATE: begin
					strobe <= !alloc_q[scan_idx] ||
						(scan_idx == stst_pkg::SLOT_W'(stst_pkg::SLOTS - 1));
					if (!alloc_q[scan_idx]) begin
						alloc_q[scan_idx] <= 1'b1;
						run_q[scan_idx]   <= 1'b0;
						rsp     <= '{status: stst_pkg::STAT_OK,
							result_slot: stst_pkg::RSLOT_W'(scan_idx), last: 1'b1};
						state_q <= S_IDLE;
					end else if (scan_idx == stst_pkg::SLOT_W'(stst_pkg::SLOTS - 1)) begin
						rsp     <= '{status: stst_pkg::STAT_FULL, result_slot: '0, last: 1'b1};
						state_q <= S_IDLE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				default: begin
					strobe  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`STST_ASSERT_NEXT(a_tick_goes_busy, start && !busy && req.action == stst_pkg::ACT_TICK, busy)
	`STST_ASSERT_NOW(a_idle_is_last, strobe && rsp.status == stst_pkg::STAT_IDLE, rsp.last)
	`STST_ASSERT_NOW(a_last_when_free, strobe && rsp.last, !busy)
	`STST_ASSERT_NOW(a_out_count, state_q == S_TICK, n_q <= stst_pkg::NOUT_W'(stst_pkg::MAX_OUT))

endmodule
